// ===== rtl/rmms_pkg.sv =====
// ----------------------------------------------------------------------------
// rmms_pkg
// Shared widths and constants for the running min/max/mean statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmms_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;

  // avg * count + sample fits in SAMPLE_BITS + COUNT_BITS bits
  localparam int PROD_BITS = SAMPLE_BITS + COUNT_BITS;
  // divisor is count + 1, which reaches 2^COUNT_BITS at saturation
  localparam int DIV_BITS  = COUNT_BITS + 1;

  // one quotient bit per divider step
  localparam int STEP_BITS = $clog2(SAMPLE_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SAMPLE_BITS - 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

endpackage

`default_nettype wire

// ===== rtl/running_min_max_avg_stats_unit.sv =====
// ----------------------------------------------------------------------------
// running_min_max_avg_stats_unit
// Running count, minimum, maximum and truncated mean of latency samples.
// ----------------------------------------------------------------------------
// Each accepted transaction returns one result: the updated sample count,
// minimum, maximum, truncated mean and the sample itself. A base measurement
// (mode 0), or an add while the count is zero, restarts the statistics and
// its result passes from the done state into the output register. An add
// measurement forms avg*count + sample in the multiplier state, runs the
// one-bit-per-cycle divider (16 steps, then a registered done flag) and
// commits in the done state, which waits while the output is stalled. The
// unit takes one transaction at a time and holds in_stall high until the
// result has been placed in the output register. The count saturates at its
// maximum, after which the weight of the old mean stays fixed.
`default_nettype none

module running_min_max_avg_stats_unit
  import rmms_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   mode,
  input  wire logic [SAMPLE_BITS-1:0] sample_ms,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [COUNT_BITS-1:0]       sample_count,
  output logic [SAMPLE_BITS-1:0]      min_ms,
  output logic [SAMPLE_BITS-1:0]      max_ms,
  output logic [SAMPLE_BITS-1:0]      avg_ms,
  output logic [SAMPLE_BITS-1:0]      last_ms
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;

  logic [COUNT_BITS-1:0]  count_reg;
  logic [SAMPLE_BITS-1:0] min_reg;
  logic [SAMPLE_BITS-1:0] max_reg;
  logic [SAMPLE_BITS-1:0] avg_reg;
  logic                   base;
  logic [SAMPLE_BITS-1:0] samp;

  logic [COUNT_BITS-1:0]  count_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic [SAMPLE_BITS-1:0] max_next;
  logic [SAMPLE_BITS-1:0] avg_next;

  logic                   in_accept;
  logic                   load_out;
  logic                   div_start;
  logic                   div_done;
  logic [PROD_BITS-1:0]   dividend;
  logic [DIV_BITS-1:0]    divisor;
  logic [SAMPLE_BITS-1:0] quotient;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_out  = (state == S_DONE) && (!out_valid || !out_stall);
  assign div_start = (state == S_MUL);

  // full-width product, no wrap
  assign dividend = PROD_BITS'(avg_reg) * PROD_BITS'(count_reg) + PROD_BITS'(samp);
  assign divisor  = {1'b0, count_reg} + DIV_BITS'(1);

  rmms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (!mode || count_reg == '0) ? S_DONE : S_MUL;
        end
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (base) begin
      count_next = COUNT_ONE;
      min_next   = samp;
      max_next   = samp;
      avg_next   = samp;
    end else begin
      count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_ONE;
      min_next   = (samp < min_reg) ? samp : min_reg;
      max_next   = (samp > max_reg) ? samp : max_reg;
      avg_next   = quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count_reg <= '0;
      min_reg   <= '0;
      max_reg   <= '0;
      avg_reg   <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
        count_reg <= count_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
        avg_reg   <= avg_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // latch the transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      base <= !mode || (count_reg == '0);
      samp <= sample_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_count <= count_next;
      min_ms       <= min_next;
      max_ms       <= max_next;
      avg_ms       <= avg_next;
      last_ms      <= samp;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_count != '0))
    else $error("result carries a zero sample count");

  a_avg_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_ms <= avg_ms) && (avg_ms <= max_ms))
    else $error("mean outside the min/max range");

  a_add_latency: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_DIV))
    else $error("multiply state did not advance to divide");
`endif

endmodule

`default_nettype wire

// ===== rtl/rmms_div.sv =====
// ----------------------------------------------------------------------------
// rmms_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in SAMPLE_BITS, so the upper dividend bits seed the
// partial remainder and only SAMPLE_BITS steps are needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rmms_div
  import rmms_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [PROD_BITS-1:0]   dividend,
  input  wire logic [DIV_BITS-1:0]    divisor,
  output logic                        done,
  output logic [SAMPLE_BITS-1:0]      quotient
);

  logic                   busy;
  logic [STEP_BITS-1:0]   cnt;
  logic [DIV_BITS-1:0]    rem;
  logic [DIV_BITS-1:0]    dsor;
  logic [SAMPLE_BITS-1:0] quo;

  logic [DIV_BITS:0]      shifted;
  logic [DIV_BITS:0]      diff;
  logic                   ge;

  always_comb begin
    shifted = {rem, quo[SAMPLE_BITS-1]};
    ge      = (shifted >= {1'b0, dsor});
    diff    = shifted - {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_BITS'(1);
        if (cnt == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend low bits out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, dividend[PROD_BITS-1:SAMPLE_BITS]};
      quo  <= dividend[SAMPLE_BITS-1:0];
      dsor <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      quo <= {quo[SAMPLE_BITS-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire
